// ----- design/frsc_pkg.sv -----
package frsc_pkg;

  localparam int unsigned ReadingWidth = 12;
  localparam int unsigned CfgIndexWidth = 3;

  typedef logic [ReadingWidth-1:0] reading_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_WALL   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    CMD_HOLD    = 4'd0,
    CMD_STOP    = 4'd1,
    CMD_FWD     = 4'd2,
    CMD_BACK    = 4'd3,
    CMD_OBJ_L   = 4'd4,
    CMD_OBJ_R   = 4'd5,
    CMD_BACK_L  = 4'd6,
    CMD_BACK_R  = 4'd7,
    CMD_WALL_L  = 4'd8,
    CMD_WALL_R  = 4'd9,
    CMD_SHARP_L = 4'd10,
    CMD_SHARP_R = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_OBJECT   = 2'd1,
    MODE_WALL     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_CAL   = 3'd0,
    PH_WAIT  = 3'd1,
    PH_STEER = 3'd2,
    PH_LATCH = 3'd3,
    PH_RUN   = 3'd4
  } phase_t;

  localparam logic [CfgIndexWidth-1:0] CFG_RANGE_FAR     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_FOLLOW_TARGET = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RANGE_CLOSE   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_HALT_NEAR     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_WALL_TARGET   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_CORNER_LEVEL  = 3'd5;

  localparam reading_t RANGE_FAR_RST     = 12'd800;
  localparam reading_t FOLLOW_TARGET_RST = 12'd1613;
  localparam reading_t RANGE_CLOSE_RST   = 12'd3102;
  localparam reading_t HALT_NEAR_RST     = 12'd4000;
  localparam reading_t WALL_TARGET_RST   = 12'd1150;
  localparam reading_t CORNER_LEVEL_RST  = 12'd1500;

  typedef struct packed {
    reading_t range_far;
    reading_t follow_target;
    reading_t range_close;
    reading_t halt_near;
    reading_t wall_target;
    reading_t corner_level;
  } thr_t;

  typedef struct packed {
    mode_t       run_mode;
    logic [1:0]  mode_press_count;
    logic [7:0]  wall_press_count;
    phase_t      phase;
    logic [3:0]  discard_count;
    logic        left_side_flag;
    logic        right_side_flag;
  } ctl_st_t;

  typedef struct packed {
    cmd_t  cmd0;
    cmd_t  cmd1;
    logic  two;
    mode_t mode_led;
  } res_t;

endpackage

// ----- design/frsc_in_if.sv -----
interface frsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [frsc_pkg::ReadingWidth-1:0] center_reading;
  logic [frsc_pkg::ReadingWidth-1:0] left_reading;
  logic [frsc_pkg::ReadingWidth-1:0] right_reading;

  modport source (
    output valid, kind, center_reading, left_reading, right_reading,
    input  ready
  );
  modport sink (
    input  valid, kind, center_reading, left_reading, right_reading,
    output ready
  );
endinterface

// ----- design/frsc_out_if.sv -----
interface frsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [1:0] mode_led;
  logic       last;

  modport source (
    output valid, command, mode_led, last,
    input  ready
  );
  modport sink (
    input  valid, command, mode_led, last,
    output ready
  );
endinterface

// ----- design/follower_robot_steering_controller_core.sv -----
// Steering controller for a two-mode follower robot. Each request is a
// filtered sensor sample or a button press, and it answers with one or two
// motor commands, the last one flagged by last. A request taken into the input
// register moves into the result register once that register is free, and its
// first command is offered on the result channel from then on. With the output
// always ready and every request giving one command, a new request is taken in
// every cycle. The input holds off while its register is full and a command
// waits on a stalled output, and a request that gives two commands holds the
// result register until both have left, which blocks the input meanwhile; the
// output channel, one command per cycle while it is ready, sets the sustained
// rate.
module follower_robot_steering_controller_core #(
  parameter int unsigned CALIBRATION_SAMPLES = 10
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [frsc_pkg::CfgIndexWidth-1:0]       cfg_index,
  input  frsc_pkg::reading_t                       cfg_wdata,
  frsc_in_if.sink                                  in_chan,
  frsc_out_if.source                               out_chan
);
  import frsc_pkg::*;

  logic     in_valid_r;
  logic [1:0] in_kind_r;
  reading_t in_center_r;
  reading_t in_left_r;
  reading_t in_right_r;

  ctl_st_t  st_r;
  ctl_st_t  st_nxt;
  thr_t     thr_r;
  res_t     res_r;
  res_t     res_nxt;
  logic     res_valid_r;
  logic     idx_r;

  logic     out_last;
  logic     res_free;
  logic     load;

  assign out_last = !res_r.two || idx_r;
  assign res_free = !res_valid_r || (out_chan.ready && out_last);
  assign load = in_valid_r && res_free;

  assign in_chan.ready = !in_valid_r || load;

  assign out_chan.valid = res_valid_r;
  assign out_chan.command = idx_r ? res_r.cmd1 : res_r.cmd0;
  assign out_chan.mode_led = res_r.mode_led;
  assign out_chan.last = out_last;

  frsc_step #(
    .CALIBRATION_SAMPLES(CALIBRATION_SAMPLES)
  ) u_step (
    .st_cur(st_r),
    .thr(thr_r),
    .kind(in_kind_r),
    .center_reading(in_center_r),
    .left_reading(in_left_r),
    .right_reading(in_right_r),
    .st_nxt(st_nxt),
    .res_nxt(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_kind_r <= in_chan.kind;
      in_center_r <= in_chan.center_reading;
      in_left_r <= in_chan.left_reading;
      in_right_r <= in_chan.right_reading;
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      idx_r <= 1'b0;
      st_r.run_mode <= MODE_INACTIVE;
      st_r.mode_press_count <= 2'd0;
      st_r.wall_press_count <= 8'd0;
      st_r.phase <= PH_CAL;
      st_r.discard_count <= 4'd0;
      st_r.left_side_flag <= 1'b0;
      st_r.right_side_flag <= 1'b0;
      thr_r.range_far <= RANGE_FAR_RST;
      thr_r.follow_target <= FOLLOW_TARGET_RST;
      thr_r.range_close <= RANGE_CLOSE_RST;
      thr_r.halt_near <= HALT_NEAR_RST;
      thr_r.wall_target <= WALL_TARGET_RST;
      thr_r.corner_level <= CORNER_LEVEL_RST;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (load) begin
        st_r <= st_nxt;
        res_valid_r <= 1'b1;
        idx_r <= 1'b0;
      end else if (out_chan.ready && res_valid_r) begin
        if (out_last) begin
          res_valid_r <= 1'b0;
        end else begin
          idx_r <= 1'b1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RANGE_FAR:     thr_r.range_far <= cfg_wdata;
          CFG_FOLLOW_TARGET: thr_r.follow_target <= cfg_wdata;
          CFG_RANGE_CLOSE:   thr_r.range_close <= cfg_wdata;
          CFG_HALT_NEAR:     thr_r.halt_near <= cfg_wdata;
          CFG_WALL_TARGET:   thr_r.wall_target <= cfg_wdata;
          CFG_CORNER_LEVEL:  thr_r.corner_level <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  a_single_no_second: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_r.two) |-> !idx_r)
    else $error("second command selected for a single-command result");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (res_valid_r && !idx_r))
    else $error("loaded request did not reach the result register");

  a_inactive_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.run_mode == MODE_INACTIVE) == (st_r.mode_press_count == 2'd0))
    else $error("mode button count disagrees with the run mode");

  a_object_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.run_mode == MODE_OBJECT) |->
      (st_r.phase == PH_CAL || st_r.phase == PH_WAIT || st_r.phase == PH_STEER))
    else $error("object mode holds a wall phase");

endmodule

// ----- design/frsc_step.sv -----
module frsc_step #(
  parameter int unsigned CALIBRATION_SAMPLES = 10
) (
  input  frsc_pkg::ctl_st_t  st_cur,
  input  frsc_pkg::thr_t     thr,
  input  logic [1:0]         kind,
  input  frsc_pkg::reading_t center_reading,
  input  frsc_pkg::reading_t left_reading,
  input  frsc_pkg::reading_t right_reading,
  output frsc_pkg::ctl_st_t  st_nxt,
  output frsc_pkg::res_t     res_nxt
);
  import frsc_pkg::*;

  localparam logic [3:0] CalCount = 4'(CALIBRATION_SAMPLES);

  function automatic ctl_st_t set_mode(ctl_st_t s, mode_t m);
    ctl_st_t o;
    o = s;
    if (m != s.run_mode) begin
      o.run_mode = m;
      o.phase = PH_CAL;
      o.discard_count = 4'd0;
    end
    return o;
  endfunction

  ctl_st_t  st;
  cmd_t     c0;
  cmd_t     c1;
  logic [1:0] n;
  logic     go;
  phase_t   ph_after;
  logic     lhit;
  logic     rhit;
  cmd_t     lcmd;
  cmd_t     rcmd;
  reading_t a;
  reading_t l;
  reading_t r;

  always_comb begin
    st = st_cur;
    c0 = CMD_HOLD;
    c1 = CMD_HOLD;
    n = 2'd0;
    go = 1'b0;
    ph_after = PH_CAL;
    lhit = 1'b0;
    rhit = 1'b0;
    lcmd = CMD_HOLD;
    rcmd = CMD_HOLD;
    a = center_reading;
    l = left_reading;
    r = right_reading;

    unique case (kind)
      KIND_WALL: begin
        st.wall_press_count = st.wall_press_count + 8'd1;
        if (st.run_mode != MODE_INACTIVE && st.wall_press_count == 8'd1) begin
          st = set_mode(st, MODE_WALL);
        end
        if (st.run_mode != MODE_INACTIVE && st.wall_press_count == 8'd2) begin
          st = set_mode(st, MODE_OBJECT);
          st.wall_press_count = 8'd0;
        end
        c0 = CMD_STOP;
        n = 2'd1;
      end
      KIND_MODE: begin
        st.mode_press_count = st.mode_press_count + 2'd1;
        if (st.mode_press_count == 2'd1) begin
          st = set_mode(st, MODE_OBJECT);
        end
        if (st.mode_press_count == 2'd2) begin
          st = set_mode(st, MODE_INACTIVE);
          st.mode_press_count = 2'd0;
          st.wall_press_count = 8'd0;
        end
        c0 = CMD_STOP;
        n = 2'd1;
      end
      KIND_SAMPLE: begin
        if (st.run_mode == MODE_OBJECT || st.run_mode == MODE_WALL) begin
          go = 1'b1;
          ph_after = (st.run_mode == MODE_OBJECT) ? PH_WAIT : PH_LATCH;
          if (st.run_mode == MODE_OBJECT && st.phase != PH_WAIT && st.phase != PH_STEER) begin
            st.phase = PH_CAL;
          end
          if (st.run_mode == MODE_WALL && st.phase != PH_LATCH && st.phase != PH_RUN) begin
            st.phase = PH_CAL;
          end
          if (st.phase == PH_CAL) begin
            if (st.discard_count < CalCount) begin
              st.discard_count = st.discard_count + 4'd1;
              if (st.discard_count >= CalCount) begin
                st.phase = ph_after;
              end
              go = 1'b0;
            end else begin
              st.phase = ph_after;
            end
          end
        end

        if (go && st.run_mode == MODE_OBJECT) begin
          if (st.phase == PH_WAIT) begin
            if (a <= thr.range_close && a >= thr.range_far &&
                l <= thr.range_close && l >= thr.range_far &&
                r <= thr.range_close && r >= thr.range_far) begin
              st.phase = PH_STEER;
            end
          end else begin
            n = 2'd1;
            if (!((a < thr.range_close && a > thr.range_far) ||
                  (r < thr.range_close && r > thr.range_far) ||
                  (l < thr.range_close && l > thr.range_far))) begin
              st.phase = PH_CAL;
              st.discard_count = 4'd0;
              c0 = CMD_STOP;
            end else if (a > thr.follow_target && a > thr.range_far) begin
              c0 = CMD_BACK;
            end else if (a < thr.follow_target && a > thr.range_far) begin
              c0 = CMD_FWD;
            end else if (l < thr.follow_target && l > thr.range_far) begin
              c0 = CMD_OBJ_L;
            end else if (l > thr.follow_target && l < thr.range_close) begin
              c0 = CMD_BACK_R;
            end else if (r < thr.follow_target && r > thr.range_far) begin
              c0 = CMD_OBJ_R;
            end else if (r > thr.follow_target && r < thr.range_close) begin
              c0 = CMD_BACK_L;
            end else begin
              c0 = CMD_STOP;
            end
          end
        end

        if (go && st.run_mode == MODE_WALL) begin
          if (st.phase == PH_LATCH) begin
            if (l > r) begin
              st.left_side_flag = 1'b1;
            end
            if (r > l) begin
              st.right_side_flag = 1'b1;
            end
            st.phase = PH_RUN;
          end
          if (a >= thr.halt_near) begin
            if (a > thr.halt_near) begin
              st.left_side_flag = 1'b0;
              st.right_side_flag = 1'b0;
              c0 = CMD_STOP;
              n = 2'd1;
            end
            st.phase = PH_CAL;
            st.discard_count = 4'd0;
          end else begin
            if (st.left_side_flag) begin
              lhit = 1'b1;
              if (l > thr.wall_target && a < thr.corner_level) begin
                lcmd = CMD_WALL_R;
              end else if (l < thr.wall_target && a < thr.corner_level) begin
                lcmd = CMD_WALL_L;
              end else if (a > thr.corner_level && l > r) begin
                lcmd = CMD_SHARP_R;
              end else if (l < thr.range_far && a < thr.range_far) begin
                lcmd = CMD_WALL_L;
              end else begin
                lhit = 1'b0;
              end
            end
            if (st.right_side_flag) begin
              rhit = 1'b1;
              if (r > thr.wall_target && a < thr.corner_level) begin
                rcmd = CMD_WALL_L;
              end else if (r < thr.wall_target && a < thr.corner_level) begin
                rcmd = CMD_WALL_R;
              end else if (a > thr.corner_level && l < r) begin
                rcmd = CMD_SHARP_L;
              end else if (r < thr.range_far && a < thr.range_far) begin
                rcmd = CMD_WALL_R;
              end else begin
                rhit = 1'b0;
              end
            end
            if (lhit) begin
              c0 = lcmd;
              c1 = rcmd;
              n = rhit ? 2'd2 : 2'd1;
            end else if (rhit) begin
              c0 = rcmd;
              n = 2'd1;
            end
          end
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase

    st_nxt = st;
    res_nxt.cmd0 = (n == 2'd0) ? CMD_HOLD : c0;
    res_nxt.cmd1 = c1;
    res_nxt.two = (n == 2'd2);
    res_nxt.mode_led = st.run_mode;
  end

endmodule
